// ----- hdl/tbs_edf_scheduler_core_macros.svh -----
// Assertion macros for the scheduler checker
`ifndef TBS_EDF_SCHEDULER_CORE_MACROS_SVH
`define TBS_EDF_SCHEDULER_CORE_MACROS_SVH
// implication check
`define TBS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("tbs check failed");
// next-cycle check
`define TBS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("tbs check failed");
`endif

// ----- hdl/tbs_pkg.sv -----
// Package: types and constants for the EDF scheduler with bandwidth server
package tbs_pkg;
  localparam int TableDepthDefault = 16;
  localparam int TimeW = 32;
  localparam int DlW   = 40;
  localparam int CapW  = 16;
  localparam int TaskW = 8;
  localparam int InW   = 2 + TaskW + TimeW + TimeW + CapW;
  localparam int OutW  = 1 + DlW + 1 + 1 + TaskW + 1 + TimeW;
  localparam int InBytesW  = ((InW + 7) / 8) * 8;
  localparam int OutBytesW = ((OutW + 7) / 8) * 8;
  localparam logic [DlW-1:0] DlMax = '1;

  typedef enum logic [1:0] {
    OP_PERIODIC  = 2'd0,
    OP_APERIODIC = 2'd1,
    OP_TICK      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [TaskW-1:0] task_id;
    logic [TimeW-1:0] rel;
    logic [TimeW-1:0] gdl;
    logic [CapW-1:0]  cap;
  } item_t;

  typedef struct packed {
    logic             table_full;
    logic [DlW-1:0]   assigned_deadline;
    logic             run_valid;
    logic             run_aperiodic;
    logic [TaskW-1:0] run_task;
    logic             job_finished;
    logic [TimeW-1:0] tick_time;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SCAN, ST_APPLY, ST_OUT
  } state_t;
endpackage

// ----- hdl/tbs_front.sv -----
// Front end: accepts transfers, normalises capacity, two-entry queue
module tbs_front import tbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [InBytesW-1:0]  in_tdata,
  output logic                 q_valid,
  input  logic                 q_pop,
  output item_t                q_item
);
  item_t q_mem_r [2];
  logic  wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t it;
  logic push;

  always_comb begin
    it.op      = op_t'(in_tdata[1:0]);
    it.task_id = in_tdata[2 +: TaskW];
    it.rel     = in_tdata[2+TaskW +: TimeW];
    it.gdl     = in_tdata[2+TaskW+TimeW +: TimeW];
    it.cap     = in_tdata[2+TaskW+2*TimeW +: CapW];
    if (it.cap == '0) it.cap = CapW'(1);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= it;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// ----- hdl/tbs_back.sv -----
// Back end: job table, slot scan, deadline arithmetic and result register
module tbs_back import tbs_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [CapW-1:0] cfg_wdata,
  input  logic            q_valid,
  output logic            q_pop,
  input  item_t           q_item,
  output logic            res_valid,
  input  logic            res_ready,
  output result_t         res
);
  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [CapW-1:0]  scale_r;
  logic [TimeW-1:0] time_r;
  logic [DlW-1:0]   last_dl_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TimeW-1:0] rel_r  [TABLE_DEPTH];
  logic [DlW-1:0]   dl_r   [TABLE_DEPTH];
  logic [CapW-1:0]  rem_r  [TABLE_DEPTH];
  logic [TaskW:0]   task_r [TABLE_DEPTH];

  item_t           cur_r;
  logic [2*CapW-1:0] prod_r;
  logic [CntW-1:0] scan_r;
  logic            free_found_r, best_found_r;
  logic [IdxW-1:0] free_r, best_r;
  logic [DlW-1:0]  best_dl_r;
  result_t         res_r, res_nxt;
  logic            res_valid_r;

  logic [IdxW-1:0] si;
  logic            elig;
  logic [DlW:0]    base, sum;
  logic [DlW-1:0]  ap_dl;

  assign si   = scan_r[IdxW-1:0];
  assign elig = valid_r[si] && (rel_r[si] <= time_r);
  assign base = (last_dl_r > DlW'(cur_r.rel)) ? {1'b0, last_dl_r} : (DlW+1)'(cur_r.rel);
  assign sum  = base + (DlW+1)'(prod_r);
  assign ap_dl = sum[DlW] ? DlMax : sum[DlW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid && !res_valid_r) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_r == CntW'(TABLE_DEPTH - 1)) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == ST_IDLE) && q_valid && !res_valid_r;
  end

  always_comb begin
    res_nxt = '0;
    if (cur_r.op == OP_PERIODIC || cur_r.op == OP_APERIODIC) begin
      if (!free_found_r) begin
        res_nxt.table_full = 1'b1;
      end else if (cur_r.op == OP_APERIODIC) begin
        res_nxt.assigned_deadline = ap_dl;
      end else begin
        res_nxt.assigned_deadline = DlW'(cur_r.gdl);
      end
    end else if (cur_r.op == OP_TICK) begin
      res_nxt.tick_time = time_r;
      if (best_found_r) begin
        res_nxt.run_valid = 1'b1;
        res_nxt.run_aperiodic = task_r[best_r][TaskW];
        res_nxt.run_task = task_r[best_r][TaskW-1:0];
        res_nxt.job_finished = (rem_r[best_r] == CapW'(1));
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scale_r <= CapW'(1);
      time_r <= '0;
      last_dl_r <= '0;
      valid_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) scale_r <= cfg_wdata;
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (q_pop) begin
          cur_r <= q_item;
          scan_r <= '0;
          free_found_r <= 1'b0;
          best_found_r <= 1'b0;
        end
        ST_MUL: prod_r <= (2*CapW)'(cur_r.cap) * (2*CapW)'(scale_r);
        ST_SCAN: begin
          scan_r <= scan_r + CntW'(1);
          if (!valid_r[si] && !free_found_r) begin
            free_found_r <= 1'b1; free_r <= si;
          end
          if (elig && (!best_found_r || dl_r[si] < best_dl_r)) begin
            best_found_r <= 1'b1; best_r <= si; best_dl_r <= dl_r[si];
          end
        end
        ST_APPLY: begin
          res_valid_r <= 1'b1;
          res_r <= res_nxt;
          if (cur_r.op == OP_PERIODIC || cur_r.op == OP_APERIODIC) begin
            if (free_found_r) begin
              valid_r[free_r] <= 1'b1;
              rel_r[free_r]   <= cur_r.rel;
              rem_r[free_r]   <= cur_r.cap;
              task_r[free_r]  <= {cur_r.op == OP_APERIODIC, cur_r.task_id};
              if (cur_r.op == OP_APERIODIC) begin
                dl_r[free_r] <= ap_dl;
                last_dl_r <= ap_dl;
              end else begin
                dl_r[free_r] <= DlW'(cur_r.gdl);
              end
            end
          end else if (cur_r.op == OP_TICK) begin
            time_r <= time_r + TimeW'(1);
            if (best_found_r) begin
              rem_r[best_r] <= rem_r[best_r] - CapW'(1);
              if (rem_r[best_r] == CapW'(1)) begin
                valid_r[best_r] <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/tbs_edf_scheduler_core.sv -----
// Steps per item: pop in IDLE, capacity product in MUL, slot scan one slot a cycle in SCAN,
// result register in APPLY; the next item is popped only once idle with no result pending.
// A two-entry queue decouples input transfers from the back end.
// Reset (synchronous, rst_n low): time, server deadline and slot valids clear, scale is 1.
// Top level: EDF scheduler with total bandwidth server
module tbs_edf_scheduler_core import tbs_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CapW-1:0]      cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // op, task_kind_id, release_time, given_deadline, capacity
  input  logic [InBytesW-1:0]  in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // table_full, assigned_deadline, run_valid, run_aperiodic, run_task, job_finished, tick_time
  output logic [OutBytesW-1:0] out_tdata
);
  logic q_valid, q_pop;
  item_t q_item;
  result_t res;

  tbs_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .q_valid, .q_pop, .q_item
  );

  tbs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .q_valid, .q_pop, .q_item,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {{(OutBytesW-OutW){1'b0}}, res.tick_time, res.job_finished,
                      res.run_task, res.run_aperiodic, res.run_valid,
                      res.assigned_deadline, res.table_full};
endmodule

// ----- hdl/tbs_checker.sv -----
// Port-level checker for the scheduler core, bound to the top level
`include "tbs_edf_scheduler_core_macros.svh"
module tbs_checker import tbs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OutBytesW-1:0] out_tdata
);
  `TBS_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `TBS_ASSERT_IMP(a_full_no_run, clk, rst_n, out_tvalid && out_tdata[0], !out_tdata[41] && ~|out_tdata[40:1])
  `TBS_ASSERT_IMP(a_fin_run, clk, rst_n, out_tvalid && out_tdata[51], out_tdata[41])
endmodule

bind tbs_edf_scheduler_core tbs_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);

// ----- dv/tbs_edf_scheduler_core_tb.sv -----
// Self-checking testbench for the EDF scheduler core with bandwidth server
module tbs_edf_scheduler_core_tb;
  import tbs_pkg::*;

  localparam int Depth     = 16;
  localparam int CycleLimit = 600000;
  localparam int DueDepth  = 64;
  localparam int PlanDepth = 16;

  typedef struct {
    op_t              op;
    logic [TaskW-1:0] task_id;
    logic [TimeW-1:0] rel;
    logic [TimeW-1:0] gdl;
    logic [CapW-1:0]  cap;
    int               reps;
    bit               typed;
    result_t          want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CapW-1:0]      cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [InBytesW-1:0]  in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OutBytesW-1:0] out_tdata;

  // scheduler image
  logic [CapW-1:0]      m_scale;
  logic [TimeW-1:0]     m_time;
  logic [DlW-1:0]       m_server_dl;
  logic                 m_valid    [Depth];
  logic [TimeW-1:0]     m_release  [Depth];
  logic [DlW-1:0]       m_deadline [Depth];
  logic [CapW-1:0]      m_remain   [Depth];
  logic [TaskW:0]       m_task     [Depth];

  result_t   due_buf[DueDepth];
  int        due_wr;
  int        due_rd;
  plan_row_t plan[PlanDepth];
  int        n_rows;
  int        n_errors;
  int        cycles;
  bit        hold_req;
  bit        calm;

  tbs_edf_scheduler_core #(.TABLE_DEPTH(Depth)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t sched_step(op_t op, logic [TaskW-1:0] tid, logic [TimeW-1:0] rel,
                                         logic [TimeW-1:0] gdl, logic [CapW-1:0] cap_in);
    result_t  r;
    logic [CapW-1:0] cap;
    logic [DlW-1:0]  base;
    logic [DlW:0]    sum;
    logic [DlW-1:0]  dl;
    int       slot;
    int       best;
    r = '0;
    cap = (cap_in == 0) ? 16'd1 : cap_in;
    slot = -1;
    best = -1;
    if (op == OP_PERIODIC || op == OP_APERIODIC) begin
      for (int i = Depth - 1; i >= 0; i--)
        if (!m_valid[i]) slot = i;
      if (slot < 0) begin
        r.table_full = 1'b1;
      end else begin
        if (op == OP_PERIODIC) begin
          dl = {8'b0, gdl};
        end else begin
          base = (m_server_dl > {8'b0, rel}) ? m_server_dl : {8'b0, rel};
          sum = {1'b0, base} + (DlW+1)'(32'(cap) * 32'(m_scale));
          dl = (sum > {1'b0, DlMax}) ? DlMax : sum[DlW-1:0];
          m_server_dl = dl;
        end
        m_valid[slot] = 1'b1;
        m_release[slot] = rel;
        m_deadline[slot] = dl;
        m_remain[slot] = cap;
        m_task[slot] = {op == OP_APERIODIC, tid};
        r.assigned_deadline = dl;
      end
    end else if (op == OP_TICK) begin
      for (int i = 0; i < Depth; i++)
        if (m_valid[i] && m_release[i] <= m_time)
          if (best < 0 || m_deadline[i] < m_deadline[best]) best = i;
      r.tick_time = m_time;
      if (best >= 0) begin
        r.run_valid = 1'b1;
        r.run_aperiodic = m_task[best][TaskW];
        r.run_task = m_task[best][TaskW-1:0];
        m_remain[best] = m_remain[best] - 1'b1;
        if (m_remain[best] == 0) begin
          m_valid[best] = 1'b0;
          r.job_finished = 1'b1;
        end
      end
      m_time = m_time + 1'b1;
    end
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
    n_errors++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycles);
  endtask

  task automatic send_item(op_t op, logic [TaskW-1:0] tid, logic [TimeW-1:0] rel,
                           logic [TimeW-1:0] gdl, logic [CapW-1:0] cap, bit typed, result_t want);
    result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= InBytesW'({cap, gdl, rel, tid, op});
    do @(posedge clk); while (!in_tready);
    r = sched_step(op, tid, rel, gdl, cap);
    due_buf[due_wr % DueDepth] = typed ? want : r;
    due_wr++;
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle_and_set(logic [CapW-1:0] scale);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_wr != due_rd) @(posedge clk);
    repeat (Depth + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= scale;
    m_scale = scale;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int       pick;
    op_t      op;
    logic [TimeW-1:0] rel;
    logic [TimeW-1:0] gdl;
    logic [CapW-1:0]  cap;
    pick = $urandom_range(0, 99);
    op = (pick < 48) ? OP_TICK : (pick < 72) ? OP_PERIODIC : (pick < 96) ? OP_APERIODIC : OP_NONE;
    case ($urandom_range(0, 9))
      0:       rel = $urandom;
      1:       rel = m_time + $urandom_range(1, 40);
      default: rel = m_time - $urandom_range(0, 20);
    endcase
    gdl = ($urandom_range(0, 7) == 0) ? $urandom : m_time + $urandom_range(0, 60);
    case ($urandom_range(0, 49))
      0:       cap = CapW'($urandom);
      1, 2:    cap = '0;
      default: cap = CapW'($urandom_range(1, 6));
    endcase
    send_item(op, TaskW'($urandom), rel, gdl, cap, 1'b0, '0);
    sender_gap();
  endtask

  function automatic void add_row(op_t op, logic [TaskW-1:0] tid, logic [TimeW-1:0] rel,
                                  logic [TimeW-1:0] gdl, logic [CapW-1:0] cap, int reps,
                                  bit typed, result_t want);
    plan[n_rows] = '{op, tid, rel, gdl, cap, reps, typed, want};
    n_rows++;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[tbs_edf_scheduler_core] ERROR");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.table_full        = out_tdata[0];
      got.assigned_deadline = out_tdata[40:1];
      got.run_valid         = out_tdata[41];
      got.run_aperiodic     = out_tdata[42];
      got.run_task          = out_tdata[50:43];
      got.job_finished      = out_tdata[51];
      got.tick_time         = out_tdata[83:52];
      if (due_wr == due_rd) begin
        note_mismatch("unexpected transfer", out_tdata[63:0], '0);
      end else begin
        want = due_buf[due_rd % DueDepth];
        due_rd++;
        if (got.table_full != want.table_full)
          note_mismatch("table_full", 64'(got.table_full), 64'(want.table_full));
        if (got.assigned_deadline != want.assigned_deadline)
          note_mismatch("assigned_deadline", 64'(got.assigned_deadline),
                        64'(want.assigned_deadline));
        if (got.run_valid != want.run_valid)
          note_mismatch("run_valid", 64'(got.run_valid), 64'(want.run_valid));
        if (got.run_aperiodic != want.run_aperiodic)
          note_mismatch("run_aperiodic", 64'(got.run_aperiodic), 64'(want.run_aperiodic));
        if (got.run_task != want.run_task)
          note_mismatch("run_task", 64'(got.run_task), 64'(want.run_task));
        if (got.job_finished != want.job_finished)
          note_mismatch("job_finished", 64'(got.job_finished), 64'(want.job_finished));
        if (got.tick_time != want.tick_time)
          note_mismatch("tick_time", 64'(got.tick_time), 64'(want.tick_time));
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 19);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [CapW-1:0] scales[4];
    n_errors = 0;
    cycles = 0;
    due_wr = 0;
    due_rd = 0;
    n_rows = 0;
    hold_req = 1'b0;
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    m_scale = 16'd1;
    m_time = '0;
    m_server_dl = '0;
    for (int i = 0; i < Depth; i++) begin
      m_valid[i] = 1'b0;
      m_release[i] = '0;
      m_deadline[i] = '0;
      m_remain[i] = '0;
      m_task[i] = '0;
    end
    add_row(OP_TICK, 8'h00, 32'h0, 32'h0, 16'h0, 1, 1'b1, '{0, 0, 0, 0, 0, 0, 0});
    add_row(OP_NONE, 8'hFF, '1, '1, '1, 1, 1'b1, '{0, 0, 0, 0, 0, 0, 0});
    add_row(OP_PERIODIC, 8'hFF, 32'h0, '1, 16'h0, 1, 1'b1, '{0, 40'hFFFFFFFF, 0, 0, 0, 0, 0});
    add_row(OP_APERIODIC, 8'h00, 32'd5, 32'h0, 16'h0, 1, 1'b1, '{0, 40'd6, 0, 0, 0, 0, 0});
    add_row(OP_APERIODIC, 8'h5A, 32'h0, '1, '1, 1, 1'b0, '0);
    add_row(OP_PERIODIC, 8'h03, 32'h0, 32'd2, 16'd2, 1, 1'b0, '0);
    add_row(OP_PERIODIC, 8'h04, 32'h0, 32'd2, 16'd1, 1, 1'b0, '0);
    add_row(OP_TICK, 8'h00, 32'h0, 32'h0, 16'h0, 4, 1'b0, '0);
    add_row(OP_PERIODIC, 8'hA5, '1, 32'h0, 16'd1, 1, 1'b0, '0);
    add_row(OP_PERIODIC, 8'h11, 32'd1, 32'd1000, 16'd3, 14, 1'b0, '0);
    add_row(OP_PERIODIC, 8'h22, 32'h0, 32'h0, 16'd1, 1, 1'b1, '{1, 0, 0, 0, 0, 0, 0});
    add_row(OP_APERIODIC, 8'h33, '1, 32'h0, '1, 1, 1'b1, '{1, 0, 0, 0, 0, 0, 0});
    add_row(OP_TICK, 8'h00, 32'h0, 32'h0, 16'h0, 6, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < n_rows; i++)
      repeat (plan[i].reps) begin
        send_item(plan[i].op, plan[i].task_id, plan[i].rel, plan[i].gdl, plan[i].cap,
                  plan[i].typed, plan[i].want);
        sender_gap();
      end

    scales[0] = 16'hFFFF;
    scales[1] = 16'h0;
    scales[2] = CapW'($urandom_range(2, 300));
    scales[3] = 16'd1;
    for (int ph = 0; ph < 4; ph++) begin
      settle_and_set(scales[ph]);
      for (int k = 0; k < 200; k++) begin
        if (ph == 1 && k == 50) hold_req = 1'b1;
        if (ph == 2 && k == 100) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (due_wr != due_rd) @(posedge clk);
        end
        if (ph == 3 && k == 120) calm = 1'b1;
        random_item();
      end
    end
    in_tvalid <= 1'b0;

    while (due_wr != due_rd) @(posedge clk);
    repeat (Depth + 20) @(posedge clk);
    if (n_errors == 0) begin
      $display("[tbs_edf_scheduler_core] OK");
    end else begin
      $display("[tbs_edf_scheduler_core] ERROR");
    end
    $finish;
  end
endmodule
